FILE: src/adpfd_pkg.sv
// Shared types, constants and the coefficient table of the ADPCM frame decoder.
package adpfd_pkg;

   localparam int FRAME_BYTES = 15;
   localparam logic [3:0] LAST_INDEX = 4'd14;
   localparam logic [3:0] HEADER_POS = 4'd15;
   localparam logic [4:0] SHIFT_BASE = 5'd6;
   localparam logic [3:0] COEF_FLIP = 4'h8;
   localparam logic [3:0] HIGH_FLIP = 4'h8;
   localparam logic signed [31:0] PCM_MAX = 32'sd32767;
   localparam logic signed [31:0] PCM_MIN = -32'sd32767;

   typedef struct packed {
      logic [7:0] header;
      logic       bank;
      logic       clear;
   } job_type;

   typedef struct packed {
      logic       bank;
      logic [3:0] addr;
   } store_rd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic signed [7:0] k0;
      logic signed [7:0] k1;
   } coef_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_ACC
   } back_state_type;

   function automatic coef_type coef_lookup(input logic [3:0] index);
      coef_type c;
      unique case (index)
         4'd1: begin
            c.k0 = 8'sd60;
            c.k1 = 8'sd0;
         end
         4'd2: begin
            c.k0 = 8'sd115;
            c.k1 = -8'sd52;
         end
         4'd3: begin
            c.k0 = 8'sd98;
            c.k1 = -8'sd55;
         end
         4'd4: begin
            c.k0 = 8'sd122;
            c.k1 = -8'sd60;
         end
         default: begin
            c.k0 = 8'sd0;
            c.k1 = 8'sd0;
         end
      endcase
      return c;
   endfunction

endpackage

FILE: src/adpcm_frame_decoder.sv
// Top level of the ADPCM frame decoder: configuration register, front end, job queue, back end.
// The first sample of a frame is presented after its header byte passes the job queue and back end.
// Throughput: bytes transfer one per cycle while the current store bank is free and the
// job queue has room; the back end reads each byte, then multiplies and accumulates per nibble.
// Reset clears the byte position, banks, queue, predictors, channel and stereo_mode;
// the frame store is not cleared and is always written before it is read.
module adpcm_frame_decoder import adpfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_sample_channel,
   output logic               rsp_last_of_frame,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_stereo_mode
);

   logic         stereo_mode_ff, stereo_mode_in;
   logic         job_push;
   job_type      job_in_data;
   logic         job_full;
   logic         job_valid;
   job_type      job_out_data;
   logic         job_pop;
   store_rd_type store_rd;
   logic [7:0]   store_data;
   release_type  bank_release;

   assign csr_ready = 1'b1;
   assign stereo_mode_in = (csr_valid && csr_ready) ? csr_stereo_mode : stereo_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_mode_ff <= 1'b0;
      end else begin
         stereo_mode_ff <= stereo_mode_in;
      end
   end

   adpfd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_first_of_stream (req_first_of_stream),
      .job_push            (job_push),
      .job_data            (job_in_data),
      .job_full            (job_full),
      .store_rd            (store_rd),
      .store_data          (store_data),
      .bank_release        (bank_release)
   );

   adpfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop_valid (job_valid),
      .pop_data  (job_out_data),
      .pop       (job_pop)
   );

   adpfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .stereo_mode        (stereo_mode_ff),
      .job_valid          (job_valid),
      .job_data           (job_out_data),
      .job_pop            (job_pop),
      .store_rd           (store_rd),
      .store_data         (store_data),
      .bank_release       (bank_release),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pcm_sample     (rsp_pcm_sample),
      .rsp_sample_channel (rsp_sample_channel),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule

FILE: src/adpfd_front.sv
// Front end: takes stream bytes, fills a double-banked frame store and issues frame jobs.
module adpfd_front import adpfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data_byte,
   input  logic         req_first_of_stream,
   output logic         job_push,
   output job_type      job_data,
   input  logic         job_full,
   input  store_rd_type store_rd,
   output logic [7:0]   store_data,
   input  release_type  bank_release
);

   logic [7:0] store_mem [2][FRAME_BYTES];
   logic [7:0] store_data_ff;
   logic [3:0] pos_ff, pos_in;
   logic       bank_ff, bank_in;
   logic [1:0] busy_ff, busy_in;
   logic       clr_pend_ff, clr_pend_in;
   logic       accept;
   logic [3:0] eff_pos;
   logic       eff_clr;

   assign req_ready = !busy_ff[bank_ff] && !job_full;
   assign accept = req_valid && req_ready;
   assign eff_pos = req_first_of_stream ? 4'd0 : pos_ff;
   assign eff_clr = req_first_of_stream || clr_pend_ff;
   assign store_data = store_data_ff;

   always_comb begin
      pos_in = pos_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      clr_pend_in = clr_pend_ff;
      job_push = 1'b0;
      job_data.header = req_data_byte;
      job_data.bank = bank_ff;
      job_data.clear = eff_clr;
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      if (accept) begin
         if (eff_pos == HEADER_POS) begin
            job_push = 1'b1;
            busy_in[bank_ff] = 1'b1;
            bank_in = ~bank_ff;
            pos_in = 4'd0;
            clr_pend_in = 1'b0;
         end else begin
            pos_in = eff_pos + 4'd1;
            clr_pend_in = eff_clr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
         clr_pend_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
         clr_pend_ff <= clr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && eff_pos != HEADER_POS) begin
         store_mem[bank_ff][eff_pos] <= req_data_byte;
      end
      store_data_ff <= store_mem[store_rd.bank][store_rd.addr];
   end

`ifndef SYNTHESIS
   a_push_marks_busy: assert property (@(posedge clock) disable iff (reset)
      job_push |=> busy_ff[$past(bank_ff)])
      else $error("pushed frame bank not marked busy");
   a_bank_flips: assert property (@(posedge clock) disable iff (reset)
      job_push |=> bank_ff != $past(bank_ff))
      else $error("write bank did not switch after header");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      job_push |=> pos_ff == 4'd0)
      else $error("byte position not cleared after header");
`endif

endmodule

FILE: src/adpfd_queue.sv
// Two-entry job queue between the byte front end and the sample back end.
module adpfd_queue import adpfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   output logic    pop_valid,
   output job_type pop_data,
   input  logic    pop
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count did not drop on pop");
`endif

endmodule

FILE: src/adpfd_back.sv
// Back end: runs the two-tap predictor over a stored frame and drives the sample output.
module adpfd_back import adpfd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                stereo_mode,
   input  logic                job_valid,
   input  job_type             job_data,
   output logic                job_pop,
   output store_rd_type        store_rd,
   input  logic [7:0]          store_data,
   output release_type         bank_release,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_pcm_sample,
   output logic                rsp_sample_channel,
   output logic                rsp_last_of_frame
);

   back_state_type state_ff, state_in;
   logic [7:0]  header_ff, header_in;
   logic        bank_ff, bank_in;
   logic [3:0]  idx_ff, idx_in;
   logic        half_ff, half_in;
   logic        ch_ff, ch_in;
   logic        cur_ch_ff, cur_ch_in;
   logic [31:0] last_ff [2];
   logic [31:0] older_ff [2];
   logic [31:0] last_in [2];
   logic [31:0] older_in [2];
   logic [3:0]  nib_ff, nib_in;
   logic [31:0] p0_ff, p0_in;
   logic [31:0] p1_ff, p1_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] pcm_ff, pcm_in;
   logic        chan_ff, chan_in;
   logic        lof_ff, lof_in;

   coef_type    coef;
   logic [4:0]  shift;
   logic        out_free;
   logic [31:0] pred;
   logic [31:0] nib_ext;
   logic [31:0] samp;
   logic [31:0] rnd;
   logic signed [31:0] scaled;

   assign coef = coef_lookup(header_ff[7:4] ^ COEF_FLIP);
   assign shift = SHIFT_BASE + {1'b0, header_ff[3:0]};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pred = p0_ff + p1_ff + 32'd32;
   assign nib_ext = {{28{nib_ff[3]}}, nib_ff};
   assign samp = (nib_ext << shift) + 32'($signed(pred) >>> 6);
   assign rnd = samp + 32'd32;
   assign scaled = $signed(rnd) >>> 6;

   assign store_rd.bank = bank_ff;
   assign store_rd.addr = idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pcm_sample = pcm_ff;
   assign rsp_sample_channel = chan_ff;
   assign rsp_last_of_frame = lof_ff;

   always_comb begin
      state_in = state_ff;
      header_in = header_ff;
      bank_in = bank_ff;
      idx_in = idx_ff;
      half_in = half_ff;
      ch_in = ch_ff;
      cur_ch_in = cur_ch_ff;
      last_in = last_ff;
      older_in = older_ff;
      nib_in = nib_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pcm_in = pcm_ff;
      chan_in = chan_ff;
      lof_in = lof_ff;
      job_pop = 1'b0;
      bank_release.valid = 1'b0;
      bank_release.bank = bank_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               header_in = job_data.header;
               bank_in = job_data.bank;
               idx_in = 4'd0;
               half_in = 1'b0;
               if (job_data.clear) begin
                  last_in[0] = 32'd0;
                  last_in[1] = 32'd0;
                  older_in[0] = 32'd0;
                  older_in[1] = 32'd0;
                  cur_ch_in = 1'b0;
                  ch_in = 1'b0;
               end else begin
                  ch_in = stereo_mode ? cur_ch_ff : 1'b0;
               end
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_MUL;
         end
         BK_MUL: begin
            nib_in = half_ff ? (store_data[7:4] ^ HIGH_FLIP) : store_data[3:0];
            p0_in = last_ff[ch_ff] * {{24{coef.k0[7]}}, coef.k0};
            p1_in = older_ff[ch_ff] * {{24{coef.k1[7]}}, coef.k1};
            state_in = BK_ACC;
         end
         BK_ACC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (scaled > PCM_MAX) begin
                  pcm_in = 16'(PCM_MAX);
               end else if (scaled < PCM_MIN) begin
                  pcm_in = 16'(PCM_MIN);
               end else begin
                  pcm_in = scaled[15:0];
               end
               chan_in = ch_ff;
               lof_in = half_ff && idx_ff == LAST_INDEX;
               last_in[ch_ff] = samp;
               older_in[ch_ff] = last_ff[ch_ff];
               if (!half_ff) begin
                  half_in = 1'b1;
                  state_in = BK_MUL;
               end else if (idx_ff == LAST_INDEX) begin
                  cur_ch_in = stereo_mode ? ~ch_ff : 1'b0;
                  bank_release.valid = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  half_in = 1'b0;
                  idx_in = idx_ff + 4'd1;
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ch_ff <= 1'b0;
         last_ff[0] <= 32'd0;
         last_ff[1] <= 32'd0;
         older_ff[0] <= 32'd0;
         older_ff[1] <= 32'd0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ch_ff <= cur_ch_in;
         last_ff <= last_in;
         older_ff <= older_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
      bank_ff <= bank_in;
      idx_ff <= idx_in;
      half_ff <= half_in;
      ch_ff <= ch_in;
      nib_ff <= nib_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      pcm_ff <= pcm_in;
      chan_ff <= chan_in;
      lof_ff <= lof_in;
   end

`ifndef SYNTHESIS
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ACC |-> $past(state_ff) == BK_MUL || $past(state_ff) == BK_ACC)
      else $error("accumulate step entered without products");
   a_release_at_end: assert property (@(posedge clock) disable iff (reset)
      bank_release.valid |-> half_ff && idx_ff == LAST_INDEX)
      else $error("frame bank released before the last sample");
   a_mono_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !stereo_mode |-> !chan_ff)
      else $error("mono sample tagged with the right channel");
   a_last_is_high: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ACC && out_free && !half_ff |=> !lof_ff)
      else $error("frame end flag on a low nibble");
`endif

endmodule
